>>> hw/rtl/krkt_pkg.sv
package krkt_pkg;

    // Event codes carried in the mode field.
    localparam logic [2:0] MODE_PRESS_MOD   = 3'd0;
    localparam logic [2:0] MODE_RELEASE_MOD = 3'd1;
    localparam logic [2:0] MODE_PRESS_KEY   = 3'd2;
    localparam logic [2:0] MODE_RELEASE_KEY = 3'd3;
    localparam logic [2:0] MODE_CLEAR_KEYS  = 3'd4;
    localparam logic [2:0] MODE_TAKEN       = 3'd5;
    localparam logic [2:0] MODE_BUS_RESET   = 3'd6;

    // Rollover code after reset.
    localparam logic [7:0] ROLLOVER_RESET = 8'd1;

    // Key slots that appear in one output word.
    localparam int OUT_SLOTS = 6;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] code_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] modifiers;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
        logic       report_sent;
        logic       report_pending;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_mode;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hw/rtl/krkt_ctrl.sv
module krkt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  krkt_pkg::t_dp_sts i_sts,
    output krkt_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Only one event is in flight at a time.
    assign o_in_stall = (r_state != ST_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.scan_last || !i_sts.key_mode) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/krkt_datapath.sv
module krkt_datapath #(
    parameter int REPORT_BYTES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  krkt_pkg::t_in_word  i_in_word,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output krkt_pkg::t_out_word o_out_word,
    input  krkt_pkg::t_dp_cmd   i_cmd,
    output krkt_pkg::t_dp_sts   o_sts
);

    localparam int SLOTS = REPORT_BYTES - 2;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    logic [2:0]       r_mode;
    logic [7:0]       r_code;
    logic [7:0]       r_roll;
    logic [7:0]       r_mods;
    logic [7:0]       r_slots [SLOTS];
    logic             r_pend;
    logic [IDX_W-1:0] r_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_emp;
    logic [IDX_W-1:0] r_emp_idx;
    logic             r_out_valid;
    krkt_pkg::t_out_word r_out_word;

    logic [7:0]       n_mods;
    logic [7:0]       n_slots [SLOTS];
    logic             n_pend;
    logic             n_sent;
    logic [7:0]       cur_slot;
    logic [7:0]       show_slot [krkt_pkg::OUT_SLOTS];

    assign cur_slot        = r_slots[r_idx];
    assign o_sts.key_mode  = (r_mode inside {krkt_pkg::MODE_PRESS_KEY,
                                             krkt_pkg::MODE_RELEASE_KEY});
    assign o_sts.scan_last = (r_idx == LAST_IDX);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out_word;

    // Apply the event using the scan results.
    always_comb begin
        n_mods = r_mods;
        n_pend = r_pend;
        n_sent = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            n_slots[i] = r_slots[i];
        end
        case (r_mode)
            krkt_pkg::MODE_PRESS_MOD: begin
                n_mods = r_mods | r_code;
                n_sent = 1'b1;
            end
            krkt_pkg::MODE_RELEASE_MOD: begin
                n_mods = r_mods & ~r_code;
                n_sent = 1'b1;
            end
            krkt_pkg::MODE_PRESS_KEY: begin
                if (!r_hit) begin
                    n_sent = 1'b1;
                    if (r_emp) begin
                        n_slots[r_emp_idx] = r_code;
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            n_slots[i] = 8'd0;
                        end
                        n_slots[0] = r_roll;
                    end
                end
            end
            krkt_pkg::MODE_RELEASE_KEY: begin
                if (r_hit) begin
                    n_slots[r_hit_idx] = 8'd0;
                    n_sent             = 1'b1;
                end
            end
            krkt_pkg::MODE_CLEAR_KEYS: begin
                n_mods = 8'd0;
                for (int i = 0; i < SLOTS; i++) begin
                    n_slots[i] = 8'd0;
                end
            end
            krkt_pkg::MODE_TAKEN: begin
                n_pend = 1'b0;
            end
            krkt_pkg::MODE_BUS_RESET: begin
                n_mods = 8'd0;
                n_pend = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    n_slots[i] = 8'd0;
                end
            end
            default: begin
            end
        endcase
        if (n_sent) begin
            n_pend = 1'b1;
        end
    end

    // Slots shown in the output word; missing slots read as zero.
    for (genvar g = 0; g < krkt_pkg::OUT_SLOTS; g++) begin : g_show
        if (g < SLOTS) begin : g_real
            assign show_slot[g] = n_slots[g];
        end else begin : g_none
            assign show_slot[g] = 8'd0;
        end
    end

    // Event latch and slot scan, one slot per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_in_word.mode;
            r_code <= i_in_word.code_value;
            r_idx  <= '0;
        end else if (i_cmd.step && !o_sts.scan_last) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.load) begin
            r_hit <= 1'b0;
            r_emp <= 1'b0;
        end else if (i_cmd.step && o_sts.key_mode) begin
            if (!r_hit && (cur_slot == r_code)) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
            end
            if (!r_emp && (cur_slot == 8'd0)) begin
                r_emp     <= 1'b1;
                r_emp_idx <= r_idx;
            end
        end
    end

    // Report state and rollover register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mods <= 8'd0;
            r_pend <= 1'b0;
            r_roll <= krkt_pkg::ROLLOVER_RESET;
            for (int i = 0; i < SLOTS; i++) begin
                r_slots[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_roll <= i_cfg_data;
            end
            if (i_cmd.finish) begin
                r_mods <= n_mods;
                r_pend <= n_pend;
                for (int i = 0; i < SLOTS; i++) begin
                    r_slots[i] <= n_slots[i];
                end
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_word.modifiers      <= n_mods;
            r_out_word.key_slot_0     <= show_slot[0];
            r_out_word.key_slot_1     <= show_slot[1];
            r_out_word.key_slot_2     <= show_slot[2];
            r_out_word.key_slot_3     <= show_slot[3];
            r_out_word.key_slot_4     <= show_slot[4];
            r_out_word.key_slot_5     <= show_slot[5];
            r_out_word.report_sent    <= n_sent;
            r_out_word.report_pending <= n_pend;
        end
    end

endmodule

>>> hw/rtl/keyboard_report_key_tracker_core.sv
// Boot keyboard report tracker. Each input word is one event (modifier set or
// clear, key press or release, clear keys, report taken, bus reset), and each
// event gives exactly one output word holding the report after the event plus
// the sent and pending flags. For key presses and releases the scan state walks
// the REPORT_BYTES - 2 key slots one slot per cycle, and the done state then
// applies the event and registers the output word. Every other event passes
// through the scan state without comparing slots. The next event can be taken
// in the cycle after the previous word is registered. A new event is accepted
// once the previous one has reached the output register, even if that word is
// still stalled; the apply step then waits until the stalled word has been taken.
// The rollover code register may be written at any time the block is idle.
module keyboard_report_key_tracker_core #(
    parameter int REPORT_BYTES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  krkt_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output krkt_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);

    krkt_pkg::t_dp_cmd cmd;
    krkt_pkg::t_dp_sts sts;

    // The register write is always taken.
    assign o_cfg_ready = 1'b1;

    krkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    krkt_datapath #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

>>> hw/rtl/krkt_checker.sv
module krkt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input krkt_pkg::t_out_word o_out_word
);

    // A stalled output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("output word changed while stalled");

    // One event at a time: accepting a word closes the input.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while an event was in flight");

    // A word that queued a report also shows the report pending.
    a_sent_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.report_sent) |-> o_out_word.report_pending)
        else $error("report sent without pending flag");

    // A new output word only follows an accepted event.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) ##1 o_out_valid |-> $past(o_in_stall))
        else $error("output word without an event in flight");

endmodule

bind keyboard_report_key_tracker_core krkt_checker u_krkt_checker (.*);

>>> tb/sv/keyboard_report_key_tracker_core_tb.sv
module keyboard_report_key_tracker_core_tb;
    import krkt_pkg::*;

    localparam int REPORT_BYTES = 8;
    localparam int SLOT_N = REPORT_BYTES - 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_COUNT = 11;
    localparam int PHASE_WORDS = 150;
    // The mode field has one code that the block leaves unused.
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    typedef struct {
        t_in_word  word;
        bit        fixed;
        t_out_word report;
    } t_event_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = '0;

    // Tracker state kept alongside the block.
    logic [7:0] mod_byte = '0;
    logic [7:0] held_keys [SLOT_N] = '{default: '0};
    logic       report_waiting = 1'b0;
    logic [7:0] rollover_code = ROLLOVER_RESET;

    t_out_word  awaited_reports [$];
    t_event_row event_table [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         out_hold = 0;
    bit         no_idle = 1'b0;

    keyboard_report_key_tracker_core #(
        .REPORT_BYTES(REPORT_BYTES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] shown_slot(input int idx);
        return (idx < SLOT_N) ? held_keys[idx] : 8'h00;
    endfunction

    // Applies one event to the tracker state and forms the report it leaves.
    task automatic track_event(input t_in_word w, output t_out_word r);
        bit sent;
        bit hit;
        sent = 1'b0;
        hit = 1'b0;
        case (w.mode)
            MODE_PRESS_MOD: begin
                mod_byte = mod_byte | w.code_value;
                sent = 1'b1;
            end
            MODE_RELEASE_MOD: begin
                mod_byte = mod_byte & ~w.code_value;
                sent = 1'b1;
            end
            MODE_PRESS_KEY: begin
                for (int i = 0; i < SLOT_N; i++)
                    if (held_keys[i] == w.code_value) hit = 1'b1;
                // A code already held is ignored; otherwise first free slot or rollover.
                if (!hit) begin
                    sent = 1'b1;
                    for (int i = 0; i < SLOT_N && !hit; i++) begin
                        if (held_keys[i] == 8'h00) begin
                            held_keys[i] = w.code_value;
                            hit = 1'b1;
                        end
                    end
                    if (!hit) begin
                        for (int i = 0; i < SLOT_N; i++) held_keys[i] = 8'h00;
                        held_keys[0] = rollover_code;
                    end
                end
            end
            MODE_RELEASE_KEY: begin
                for (int i = 0; i < SLOT_N && !hit; i++) begin
                    if (held_keys[i] == w.code_value) begin
                        held_keys[i] = 8'h00;
                        hit = 1'b1;
                    end
                end
                sent = hit;
            end
            MODE_CLEAR_KEYS: begin
                mod_byte = 8'h00;
                for (int i = 0; i < SLOT_N; i++) held_keys[i] = 8'h00;
            end
            MODE_TAKEN: begin
                report_waiting = 1'b0;
            end
            MODE_BUS_RESET: begin
                mod_byte = 8'h00;
                for (int i = 0; i < SLOT_N; i++) held_keys[i] = 8'h00;
                report_waiting = 1'b0;
            end
            default: begin
            end
        endcase
        if (sent) report_waiting = 1'b1;
        r.modifiers = mod_byte;
        r.key_slot_0 = shown_slot(0);
        r.key_slot_1 = shown_slot(1);
        r.key_slot_2 = shown_slot(2);
        r.key_slot_3 = shown_slot(3);
        r.key_slot_4 = shown_slot(4);
        r.key_slot_5 = shown_slot(5);
        r.report_sent = sent;
        r.report_pending = report_waiting;
    endtask

    // Report with only the modifier byte and the first slot in use.
    function automatic t_out_word short_report(input logic [7:0] mods, input logic [7:0] slot0,
                                               input logic sent, input logic pend);
        t_out_word r;
        r = '0;
        r.modifiers = mods;
        r.key_slot_0 = slot0;
        r.report_sent = sent;
        r.report_pending = pend;
        return r;
    endfunction

    task automatic add_row(input logic [2:0] mode, input logic [7:0] code, input bit fixed,
                           input t_out_word report);
        t_event_row row;
        row.word.mode = mode;
        row.word.code_value = code;
        row.fixed = fixed;
        row.report = report;
        event_table.push_back(row);
    endtask

    // Sends one word after a random gap (none when no_idle is set) and records the report it must produce.
    task automatic send_event(input t_in_word w, input bit fixed, input t_out_word report);
        int gap;
        t_out_word predicted;
        gap = no_idle ? 0 : $urandom_range(9, 0);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        track_event(w, predicted);
        awaited_reports.push_back(fixed ? report : predicted);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
    endtask

    // The register is only written once the block has gone quiet.
    task automatic write_rollover(input logic [7:0] value);
        wait_drained();
        repeat (REPORT_BYTES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        rollover_code = value;
    endtask

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Output stall: a fresh hold length is drawn after every accepted word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_hold = 0;
            i_out_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            out_hold = no_idle ? 0 : $urandom_range(9, 0);
            i_out_stall <= (out_hold != 0);
        end else if (out_hold != 0) begin
            out_hold = out_hold - 1;
            i_out_stall <= (out_hold != 0);
        end
    end

    // Each accepted word is compared with the oldest awaited report.
    always @(posedge i_clk) begin : report_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_reports.size() == 0) begin
                $error("unexpected output word %h", o_out_word);
                mismatch_count++;
            end else begin
                want = awaited_reports.pop_front();
                cmp_field("modifiers", want.modifiers, o_out_word.modifiers);
                cmp_field("key_slot_0", want.key_slot_0, o_out_word.key_slot_0);
                cmp_field("key_slot_1", want.key_slot_1, o_out_word.key_slot_1);
                cmp_field("key_slot_2", want.key_slot_2, o_out_word.key_slot_2);
                cmp_field("key_slot_3", want.key_slot_3, o_out_word.key_slot_3);
                cmp_field("key_slot_4", want.key_slot_4, o_out_word.key_slot_4);
                cmp_field("key_slot_5", want.key_slot_5, o_out_word.key_slot_5);
                cmp_field("report_sent", 8'(want.report_sent),
                          8'(o_out_word.report_sent));
                cmp_field("report_pending", 8'(want.report_pending),
                          8'(o_out_word.report_pending));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** keyboard_report_key_tracker_core: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_word  w;
        t_out_word no_report;
        int        pick;
        logic [7:0] setting;

        no_report = '0;

        // Directed events: empty report, extremes of the modifiers and first key slot, rollover.
        add_row(MODE_PRESS_KEY, 8'h00, 1'b1, short_report(8'h00, 8'h00, 1'b0, 1'b0));
        add_row(MODE_RELEASE_KEY, 8'h55, 1'b1, short_report(8'h00, 8'h00, 1'b0, 1'b0));
        add_row(MODE_RELEASE_KEY, 8'h00, 1'b1, short_report(8'h00, 8'h00, 1'b1, 1'b1));
        add_row(MODE_TAKEN, 8'h00, 1'b1, short_report(8'h00, 8'h00, 1'b0, 1'b0));
        add_row(MODE_PRESS_MOD, 8'hFF, 1'b1, short_report(8'hFF, 8'h00, 1'b1, 1'b1));
        add_row(MODE_RELEASE_MOD, 8'h0F, 1'b1, short_report(8'hF0, 8'h00, 1'b1, 1'b1));
        add_row(MODE_RELEASE_MOD, 8'hFF, 1'b1, short_report(8'h00, 8'h00, 1'b1, 1'b1));
        add_row(MODE_PRESS_KEY, 8'hFF, 1'b1, short_report(8'h00, 8'hFF, 1'b1, 1'b1));
        add_row(MODE_PRESS_KEY, 8'h01, 1'b0, no_report);
        add_row(MODE_PRESS_KEY, 8'h04, 1'b0, no_report);
        add_row(MODE_PRESS_KEY, 8'h80, 1'b0, no_report);
        add_row(MODE_PRESS_KEY, 8'h7F, 1'b0, no_report);
        add_row(MODE_PRESS_KEY, 8'h2A, 1'b0, no_report);
        add_row(MODE_PRESS_KEY, 8'h04, 1'b0, no_report);
        add_row(MODE_RELEASE_KEY, 8'h00, 1'b0, no_report);
        add_row(MODE_PRESS_KEY, 8'h00, 1'b1, short_report(8'h00, ROLLOVER_RESET, 1'b1, 1'b1));
        add_row(MODE_PRESS_KEY, ROLLOVER_RESET, 1'b0, no_report);
        add_row(MODE_PRESS_MOD, 8'h22, 1'b0, no_report);
        add_row(MODE_CLEAR_KEYS, 8'h5A, 1'b1, short_report(8'h00, 8'h00, 1'b0, 1'b1));
        add_row(MODE_PRESS_KEY, 8'h33, 1'b0, no_report);
        add_row(MODE_RELEASE_KEY, 8'h33, 1'b0, no_report);
        add_row(MODE_UNUSED, 8'hFF, 1'b0, no_report);
        add_row(MODE_BUS_RESET, 8'hAA, 1'b1, short_report(8'h00, 8'h00, 1'b0, 1'b0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (event_table[k]) send_event(event_table[k].word, event_table[k].fixed,
                                            event_table[k].report);

        // Random phases, each under its own rollover code.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: setting = 8'h00;
                1: setting = 8'hFF;
                2: setting = 8'h80;
                default: setting = 8'($urandom_range(255, 0));
            endcase
            write_rollover(setting);
            no_idle = (phase % 4 == 2);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(99, 0);
                w.code_value = 8'($urandom_range(255, 0));
                // Keys mostly come from a small set so that repeats, releases and
                // full reports happen often.
                if (pick < 65) begin
                    w.mode = (pick < 40) ? MODE_PRESS_KEY : MODE_RELEASE_KEY;
                    pick = $urandom_range(99, 0);
                    if (pick < 70) w.code_value = 8'($urandom_range(10, 1));
                    else if (pick < 76) w.code_value = 8'h00;
                end else if (pick < 75) begin
                    w.mode = MODE_PRESS_MOD;
                end else if (pick < 83) begin
                    w.mode = MODE_RELEASE_MOD;
                end else if (pick < 88) begin
                    w.mode = MODE_CLEAR_KEYS;
                end else if (pick < 94) begin
                    w.mode = MODE_TAKEN;
                end else if (pick < 97) begin
                    w.mode = MODE_BUS_RESET;
                end else begin
                    w.mode = MODE_UNUSED;
                end
                send_event(w, 1'b0, no_report);
            end
        end

        wait_drained();
        repeat (4 * REPORT_BYTES) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_reports.size() == 0) begin
            $display("** keyboard_report_key_tracker_core: PASSED **");
        end else begin
            $display("** keyboard_report_key_tracker_core: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/krkt_pkg.sv
hw/rtl/krkt_ctrl.sv
hw/rtl/krkt_datapath.sv
hw/rtl/keyboard_report_key_tracker_core.sv
hw/rtl/krkt_checker.sv
tb/sv/keyboard_report_key_tracker_core_tb.sv
